/* hdl/crts_pkg.sv */
// shared types and constants of the counter recharge task scheduler
package crts_pkg;

	localparam int MAX_TASKS_DEF      = 16;
	localparam int RECHARGE_LIMIT_DEF = 16;
	localparam int PID_W              = 16;
	localparam int PRIO_W             = 8;
	localparam int TICK_W             = 10;
	localparam int DEPTH_W            = 8;
	localparam logic [7:0] BOOT_PRIO_RST = 8'd1;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_TICK  = 4'd1,
		CMD_YIELD = 4'd2,
		CMD_KILL  = 4'd3,
		CMD_WAIT  = 4'd4,
		CMD_CHECK = 4'd5,
		CMD_REAP  = 4'd6,
		CMD_POFF  = 4'd7,
		CMD_PON   = 4'd8,
		CMD_FIND  = 4'd9
	} cmd_e;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_NOTFOUND = 2'd2,
		STS_NOPROG   = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		SLOT_FREE = 2'd0,
		SLOT_RUN  = 2'd1,
		SLOT_WAIT = 2'd2,
		SLOT_STOP = 2'd3
	} slot_state_e;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_ADD, S_FRUN, S_FANY, S_REM, S_PICK, S_RECH, S_CHKO, S_CHKI, S_FIN
	} fsm_state_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_DISP, OP_ADD, OP_FRUN, OP_FANY, OP_REM, OP_PICK, OP_RECH, OP_CHKO,
		OP_CHKI, OP_FIN
	} dp_op_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [PID_W-1:0]   task_pid;
		logic [PID_W-1:0]   wait_pid;
		logic [PRIO_W-1:0]  prio;
		logic [DEPTH_W-1:0] lock_depth_init;
		logic               waitable;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PID_W-1:0] answer_pid;
		logic [PID_W-1:0] running_pid;
		logic             switched;
	} out_item_t;

	typedef struct packed {
		dp_op_t op;
		logic   load;
		logic   clr;
	} ctl_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic       run_end;
		logic       all_end;
		logic       o_end;
		logic       hit;
		logic       tick_stop;
		logic       pick_any;
		logic       pick_nz;
		logic       rech_lim;
		logic       out_free;
	} sts_t;

endpackage

/* hdl/crts_ctrl.sv */
// sequencing state machine of the scheduler
module crts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  crts_pkg::sts_t sts,
	output crts_pkg::ctl_t ctl
);

	crts_pkg::fsm_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crts_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			crts_pkg::S_IDLE: begin
				if (req_valid) state_nx = crts_pkg::S_DISP;
			end
			crts_pkg::S_DISP: begin
				unique case (sts.cmd)
					crts_pkg::CMD_ADD:   state_nx = crts_pkg::S_ADD;
					crts_pkg::CMD_TICK:  state_nx = sts.tick_stop ? crts_pkg::S_FIN : crts_pkg::S_PICK;
					crts_pkg::CMD_YIELD: state_nx = crts_pkg::S_PICK;
					crts_pkg::CMD_KILL,
					crts_pkg::CMD_WAIT,
					crts_pkg::CMD_FIND:  state_nx = crts_pkg::S_FRUN;
					crts_pkg::CMD_CHECK: state_nx = crts_pkg::S_CHKO;
					default:             state_nx = crts_pkg::S_FIN;
				endcase
			end
			crts_pkg::S_ADD: begin
				if (sts.all_end || sts.hit) state_nx = crts_pkg::S_FIN;
			end
			crts_pkg::S_FRUN: begin
				priority if (sts.run_end) begin
					state_nx = crts_pkg::S_FIN;
				end else if (sts.hit) begin
					if (sts.cmd == crts_pkg::CMD_FIND) state_nx = crts_pkg::S_FIN;
					else if (sts.cmd == crts_pkg::CMD_KILL) state_nx = crts_pkg::S_REM;
					else state_nx = crts_pkg::S_FANY;
				end else begin
					state_nx = state_q;
				end
			end
			crts_pkg::S_FANY: begin
				priority if (sts.all_end) state_nx = crts_pkg::S_FIN;
				else if (sts.hit) state_nx = crts_pkg::S_REM;
				else state_nx = state_q;
			end
			crts_pkg::S_REM: begin
				if (sts.run_end)
					state_nx = (sts.cmd == crts_pkg::CMD_KILL) ? crts_pkg::S_PICK : crts_pkg::S_FIN;
			end
			crts_pkg::S_PICK: begin
				if (sts.run_end) begin
					if (!sts.pick_any || sts.pick_nz || sts.rech_lim) state_nx = crts_pkg::S_FIN;
					else state_nx = crts_pkg::S_RECH;
				end
			end
			crts_pkg::S_RECH: begin
				if (sts.run_end) state_nx = crts_pkg::S_PICK;
			end
			crts_pkg::S_CHKO: begin
				priority if (sts.o_end) state_nx = crts_pkg::S_FIN;
				else if (sts.hit) state_nx = crts_pkg::S_CHKI;
				else state_nx = state_q;
			end
			crts_pkg::S_CHKI: begin
				if (sts.all_end || sts.hit) state_nx = crts_pkg::S_CHKO;
			end
			crts_pkg::S_FIN: begin
				if (sts.out_free) state_nx = crts_pkg::S_IDLE;
			end
			default: state_nx = crts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == crts_pkg::S_IDLE);
		ctl.load  = (state_q == crts_pkg::S_IDLE) && req_valid;
		ctl.clr   = (state_nx != state_q);
		unique case (state_q)
			crts_pkg::S_IDLE: ctl.op = crts_pkg::OP_IDLE;
			crts_pkg::S_DISP: ctl.op = crts_pkg::OP_DISP;
			crts_pkg::S_ADD:  ctl.op = crts_pkg::OP_ADD;
			crts_pkg::S_FRUN: ctl.op = crts_pkg::OP_FRUN;
			crts_pkg::S_FANY: ctl.op = crts_pkg::OP_FANY;
			crts_pkg::S_REM:  ctl.op = crts_pkg::OP_REM;
			crts_pkg::S_PICK: ctl.op = crts_pkg::OP_PICK;
			crts_pkg::S_RECH: ctl.op = crts_pkg::OP_RECH;
			crts_pkg::S_CHKO: ctl.op = crts_pkg::OP_CHKO;
			crts_pkg::S_CHKI: ctl.op = crts_pkg::OP_CHKI;
			crts_pkg::S_FIN:  ctl.op = crts_pkg::OP_FIN;
			default:          ctl.op = crts_pkg::OP_IDLE;
		endcase
	end

endmodule

/* hdl/crts_dp.sv */
// task table, run order and result register of the scheduler
module crts_dp #(
	parameter int MAX_TASKS      = crts_pkg::MAX_TASKS_DEF,
	parameter int RECHARGE_LIMIT = crts_pkg::RECHARGE_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crts_pkg::ctl_t      ctl,
	output crts_pkg::sts_t      sts,
	input  crts_pkg::in_item_t  req,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                rsp_ready,
	output logic                rsp_valid,
	output crts_pkg::out_item_t rsp
);

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int RW = $clog2(RECHARGE_LIMIT + 1);
	localparam int TW = crts_pkg::TICK_W;

	crts_pkg::slot_state_e st_q [MAX_TASKS];
	logic [15:0]   pid_q  [MAX_TASKS];
	logic [7:0]    prio_q [MAX_TASKS];
	logic [TW-1:0] tck_q  [MAX_TASKS];
	logic [7:0]    lock_q [MAX_TASKS];
	logic          wbl_q  [MAX_TASKS];
	logic [15:0]   won_q  [MAX_TASKS];
	logic [SW-1:0] ro_q   [MAX_TASKS];
	logic [LW-1:0] rlen_q, i_q, j_q, o_q;
	logic [SW-1:0] cur_q, before_q, sel_q, best_q;
	logic [15:0]   npid_q;
	logic          any_q;
	logic [TW-1:0] bt_q;
	logic [RW-1:0] rech_q;
	crts_pkg::in_item_t  item_q;
	logic [1:0]          status_q;
	logic [15:0]         answer_q;
	logic                rsp_valid_q;
	crts_pkg::out_item_t rsp_q;

	logic [SW-1:0] ii, oi, ro_i, rlen_i;
	logic [TW-1:0] cur_tck, tick_new, rech_val;
	logic          hit, wake, run_end, all_end, o_end, out_free;

	always_comb begin
		ii       = i_q[SW-1:0];
		oi       = o_q[SW-1:0];
		rlen_i   = rlen_q[SW-1:0];
		ro_i     = ro_q[ii];
		run_end  = (i_q >= rlen_q);
		all_end  = (i_q == LW'(MAX_TASKS));
		o_end    = (o_q == LW'(MAX_TASKS));
		cur_tck  = tck_q[cur_q];
		tick_new = cur_tck - TW'(cur_tck != '0);
		rech_val = TW'({1'b0, tck_q[ro_i][TW-1:1]} + {{(TW-8){1'b0}}, prio_q[ro_i]});
		wake     = wbl_q[ii] && (st_q[ii] == crts_pkg::SLOT_STOP);
		out_free = !rsp_valid_q || rsp_ready;
		unique case (ctl.op)
			crts_pkg::OP_ADD:  hit = (st_q[ii] == crts_pkg::SLOT_FREE);
			crts_pkg::OP_FRUN: hit = (pid_q[ro_i] == item_q.task_pid);
			crts_pkg::OP_FANY: hit = (st_q[ii] != crts_pkg::SLOT_FREE) &&
				(pid_q[ii] == item_q.wait_pid);
			crts_pkg::OP_CHKO: hit = (st_q[oi] == crts_pkg::SLOT_WAIT);
			crts_pkg::OP_CHKI: hit = (st_q[ii] != crts_pkg::SLOT_FREE) &&
				(pid_q[ii] == won_q[oi]);
			default:           hit = 1'b0;
		endcase
		sts.cmd       = item_q.cmd;
		sts.run_end   = run_end;
		sts.all_end   = all_end;
		sts.o_end     = o_end;
		sts.hit       = hit;
		sts.tick_stop = (tick_new != '0) || (lock_q[cur_q] != '0);
		sts.pick_any  = any_q;
		sts.pick_nz   = (bt_q != '0);
		sts.rech_lim  = (rech_q >= RW'(RECHARGE_LIMIT));
		sts.out_free  = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_TASKS; k++) begin
				st_q[k]   <= crts_pkg::SLOT_FREE;
				pid_q[k]  <= '0;
				prio_q[k] <= '0;
				tck_q[k]  <= '0;
				lock_q[k] <= '0;
				wbl_q[k]  <= 1'b0;
				ro_q[k]   <= '0;
			end
			st_q[0]     <= crts_pkg::SLOT_RUN;
			prio_q[0]   <= crts_pkg::BOOT_PRIO_RST;
			rlen_q      <= LW'(1);
			cur_q       <= '0;
			before_q    <= '0;
			sel_q       <= '0;
			best_q      <= '0;
			npid_q      <= 16'd1;
			i_q         <= '0;
			j_q         <= '0;
			o_q         <= '0;
			any_q       <= 1'b0;
			bt_q        <= '0;
			rech_q      <= '0;
			item_q      <= '0;
			status_q    <= crts_pkg::STS_OK;
			answer_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we && st_q[0] != crts_pkg::SLOT_FREE && pid_q[0] == '0)
				prio_q[0] <= cfg_wdata;
			if (rsp_valid_q && rsp_ready && ctl.op != crts_pkg::OP_FIN) rsp_valid_q <= 1'b0;
			unique case (ctl.op)
				crts_pkg::OP_IDLE: begin
					// scan counters are cleared by the state change
					if (ctl.load) begin
						item_q   <= req;
						before_q <= cur_q;
						status_q <= crts_pkg::STS_OK;
						answer_q <= '0;
						o_q      <= '0;
						rech_q   <= '0;
					end
				end
				crts_pkg::OP_DISP: begin
					unique case (item_q.cmd)
						crts_pkg::CMD_TICK:  tck_q[cur_q] <= tick_new;
						crts_pkg::CMD_YIELD: tck_q[cur_q] <= '0;
						crts_pkg::CMD_REAP: begin
							for (int k = 0; k < MAX_TASKS; k++)
								if (st_q[k] == crts_pkg::SLOT_STOP && SW'(k) != cur_q)
									st_q[k] <= crts_pkg::SLOT_FREE;
						end
						crts_pkg::CMD_POFF: begin
							if (lock_q[cur_q] != 8'hFF) lock_q[cur_q] <= lock_q[cur_q] + 8'd1;
						end
						crts_pkg::CMD_PON: begin
							if (lock_q[cur_q] != 8'h00) lock_q[cur_q] <= lock_q[cur_q] - 8'd1;
						end
						default: ;
					endcase
				end
				crts_pkg::OP_ADD: begin
					priority if (all_end) begin
						status_q <= crts_pkg::STS_FULL;
					end else if (hit) begin
						st_q[ii]   <= crts_pkg::SLOT_RUN;
						pid_q[ii]  <= npid_q;
						prio_q[ii] <= item_q.prio;
						tck_q[ii]  <= '0;
						lock_q[ii] <= item_q.lock_depth_init;
						wbl_q[ii]  <= item_q.waitable;
						answer_q   <= npid_q;
						npid_q     <= npid_q + 16'd1;
						if (rlen_q < LW'(MAX_TASKS)) begin
							ro_q[rlen_i] <= ii;
							rlen_q       <= rlen_q + LW'(1);
						end
					end else begin
						i_q <= i_q + LW'(1);
					end
				end
				crts_pkg::OP_FRUN: begin
					priority if (run_end) begin
						status_q <= crts_pkg::STS_NOTFOUND;
					end else if (hit) begin
						sel_q <= ro_i;
						if (item_q.cmd == crts_pkg::CMD_FIND) answer_q <= pid_q[ro_i];
						if (item_q.cmd == crts_pkg::CMD_KILL) st_q[ro_i] <= crts_pkg::SLOT_STOP;
					end else begin
						i_q <= i_q + LW'(1);
					end
				end
				crts_pkg::OP_FANY: begin
					priority if (all_end) status_q <= crts_pkg::STS_NOTFOUND;
					else if (hit) st_q[sel_q] <= crts_pkg::SLOT_WAIT;
					else i_q <= i_q + LW'(1);
				end
				crts_pkg::OP_REM: begin
					if (run_end) begin
						rlen_q <= j_q;
						if (item_q.cmd == crts_pkg::CMD_KILL) tck_q[cur_q] <= '0;
					end else begin
						if (ro_i != sel_q) begin
							ro_q[j_q[SW-1:0]] <= ro_i;
							j_q <= j_q + LW'(1);
						end
						i_q <= i_q + LW'(1);
					end
				end
				crts_pkg::OP_PICK: begin
					if (!run_end) begin
						if (st_q[ro_i] == crts_pkg::SLOT_RUN && (!any_q || tck_q[ro_i] > bt_q)) begin
							any_q  <= 1'b1;
							best_q <= ro_i;
							bt_q   <= tck_q[ro_i];
						end
						i_q <= i_q + LW'(1);
					end else if (any_q && bt_q != '0) begin
						cur_q <= best_q;
					end else if (any_q && rech_q >= RW'(RECHARGE_LIMIT)) begin
						status_q <= crts_pkg::STS_NOPROG;
					end
				end
				crts_pkg::OP_RECH: begin
					if (run_end) begin
						rech_q <= rech_q + RW'(1);
					end else begin
						tck_q[ro_i] <= rech_val;
						i_q <= i_q + LW'(1);
					end
				end
				crts_pkg::OP_CHKO: begin
					if (!o_end && !hit) o_q <= o_q + LW'(1);
				end
				crts_pkg::OP_CHKI: begin
					priority if (all_end) begin
						o_q <= o_q + LW'(1);
					end else if (hit) begin
						if (wake) begin
							st_q[oi] <= crts_pkg::SLOT_RUN;
							if (rlen_q < LW'(MAX_TASKS)) begin
								ro_q[rlen_i] <= oi;
								rlen_q       <= rlen_q + LW'(1);
							end
						end
						o_q <= o_q + LW'(1);
					end else begin
						i_q <= i_q + LW'(1);
					end
				end
				crts_pkg::OP_FIN: begin
					if (out_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= status_q;
						rsp_q.answer_pid  <= answer_q;
						rsp_q.running_pid <= pid_q[cur_q];
						rsp_q.switched    <= (cur_q != before_q);
					end
				end
				default: ;
			endcase
			if (ctl.clr) begin
				i_q   <= '0;
				j_q   <= '0;
				any_q <= 1'b0;
				bt_q  <= '0;
			end
		end
	end

	// waited-for pid, defined only once a wait command has written it
	always_ff @(posedge clk) begin
		if (ctl.op == crts_pkg::OP_FANY && !all_end && hit) won_q[sel_q] <= item_q.wait_pid;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/counter_recharge_task_scheduler.sv */
// simple events go from dispatch straight to the finish state; others first walk the table slot by slot
// a schedule runs a pick pass over the run order, then a recharge pass and another pick pass as needed
// worst case a kill: find, remove, then a schedule with up to RECHARGE_LIMIT recharge passes
// one item at a time; the next item is taken once the result is in the output register
// reset: asynchronous, boot task running in slot zero with pid zero, next pid one
module counter_recharge_task_scheduler #(
	parameter int MAX_TASKS      = crts_pkg::MAX_TASKS_DEF,
	parameter int RECHARGE_LIMIT = crts_pkg::RECHARGE_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// event items
	input  logic                req_valid,
	output logic                req_ready,
	input  crts_pkg::in_item_t  req,
	// result items
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output crts_pkg::out_item_t rsp,
	// boot task priority register
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata
);

	// command and status between sequencer and datapath
	crts_pkg::ctl_t ctl;
	crts_pkg::sts_t sts;

	// sequencer walks the table one slot a cycle
	crts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// task table, run order and output register
	crts_dp #(
		.MAX_TASKS      (MAX_TASKS),
		.RECHARGE_LIMIT (RECHARGE_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

/* hdl/crts_chk.sv */
// port level checks of the scheduler
module crts_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input crts_pkg::out_item_t rsp
);

	// a waiting result holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while busy");

	// a full table changes nothing
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == crts_pkg::STS_FULL |-> !rsp.switched && rsp.answer_pid == '0)
		else $error("full table result inconsistent");

	// a lookup miss changes nothing
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == crts_pkg::STS_NOTFOUND |-> !rsp.switched && rsp.answer_pid == '0)
		else $error("lookup miss result inconsistent");

endmodule

bind counter_recharge_task_scheduler crts_chk u_crts_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

/* dv/tb.sv */
// testbench of the counter recharge task scheduler: directed and random events, scoreboard check
module tb;
	import crts_pkg::*;

	// predicts each result from a software copy of the task table
	class sched_scoreboard;
		out_item_t   pending[$];
		int          errors;
		logic [7:0]  boot_prio;
		slot_state_e st[16];
		logic [15:0] pid[16];
		logic [7:0]  pr[16];
		logic [9:0]  tk[16];
		logic [7:0]  dep[16];
		bit          wab[16];
		logic [15:0] won[16];
		int          ord[16];
		int          rlen;
		int          cur;
		logic [15:0] npid;

		function new();
			errors = 0;
			boot_prio = BOOT_PRIO_RST;
			for (int s = 0; s < 16; s++) begin
				st[s] = SLOT_FREE;
				pid[s] = 0;
				pr[s] = 0;
				tk[s] = 0;
				dep[s] = 0;
				wab[s] = 0;
				won[s] = 0;
				ord[s] = 0;
			end
			st[0] = SLOT_RUN;
			pr[0] = boot_prio;
			rlen = 1;
			cur = 0;
			npid = 1;
		endfunction

		function void write_boot(logic [7:0] v);
			boot_prio = v;
			if (st[0] != SLOT_FREE && pid[0] == 0)
				pr[0] = v;
		endfunction

		function int in_run(logic [15:0] p);
			for (int i = 0; i < rlen; i++)
				if (pid[ord[i]] == p)
					return ord[i];
			return -1;
		endfunction

		function int any_slot(logic [15:0] p);
			for (int s = 0; s < 16; s++)
				if (st[s] != SLOT_FREE && pid[s] == p)
					return s;
			return -1;
		endfunction

		function void drop(int slot);
			int j;
			j = 0;
			for (int i = 0; i < rlen; i++)
				if (ord[i] != slot) begin
					ord[j] = ord[i];
					j++;
				end
			rlen = j;
		endfunction

		function void push(int slot);
			if (rlen < 16) begin
				ord[rlen] = slot;
				rlen++;
			end
		endfunction

		// largest counter wins, first in queue order on a tie; recharge when all are zero
		function status_e pick();
			int best;
			int recharges;
			logic [9:0] bt;
			recharges = 0;
			forever begin
				best = -1;
				bt = 0;
				for (int i = 0; i < rlen; i++) begin
					if (st[ord[i]] != SLOT_RUN)
						continue;
					if (best < 0 || tk[ord[i]] > bt) begin
						best = ord[i];
						bt = tk[ord[i]];
					end
				end
				if (best < 0)
					return STS_OK;
				if (bt != 0) begin
					cur = best;
					return STS_OK;
				end
				if (recharges >= RECHARGE_LIMIT_DEF)
					return STS_NOPROG;
				for (int i = 0; i < rlen; i++)
					tk[ord[i]] = (tk[ord[i]] >> 1) + 10'(pr[ord[i]]);
				recharges++;
			end
		endfunction

		function void note(in_item_t it);
			out_item_t exp_item;
			int s;
			int t;
			int was;
			status_e sts;
			logic [15:0] ans;
			sts = STS_OK;
			ans = 0;
			was = cur;
			case (it.cmd)
				CMD_ADD: begin
					s = 0;
					while (s < 16 && st[s] != SLOT_FREE)
						s++;
					if (s >= 16)
						sts = STS_FULL;
					else begin
						st[s] = SLOT_RUN;
						pid[s] = npid;
						pr[s] = it.prio;
						tk[s] = 0;
						dep[s] = it.lock_depth_init;
						wab[s] = it.waitable;
						won[s] = 0;
						ans = npid;
						npid++;
						push(s);
					end
				end
				CMD_TICK: begin
					if (tk[cur] > 0)
						tk[cur]--;
					if (tk[cur] == 0 && dep[cur] == 0)
						sts = pick();
				end
				CMD_YIELD: begin
					tk[cur] = 0;
					sts = pick();
				end
				CMD_KILL: begin
					s = in_run(it.task_pid);
					if (s < 0)
						sts = STS_NOTFOUND;
					else begin
						st[s] = SLOT_STOP;
						drop(s);
						tk[cur] = 0;
						sts = pick();
					end
				end
				CMD_WAIT: begin
					s = in_run(it.task_pid);
					t = any_slot(it.wait_pid);
					if (s < 0 || t < 0)
						sts = STS_NOTFOUND;
					else begin
						won[s] = it.wait_pid;
						st[s] = SLOT_WAIT;
						drop(s);
					end
				end
				CMD_CHECK: begin
					for (s = 0; s < 16; s++) begin
						if (st[s] != SLOT_WAIT)
							continue;
						t = any_slot(won[s]);
						if (t >= 0 && wab[t] && st[t] == SLOT_STOP) begin
							st[s] = SLOT_RUN;
							push(s);
						end
					end
				end
				CMD_REAP: begin
					for (s = 0; s < 16; s++)
						if (st[s] == SLOT_STOP && s != cur)
							st[s] = SLOT_FREE;
				end
				CMD_POFF: if (dep[cur] != 8'hff) dep[cur]++;
				CMD_PON:  if (dep[cur] != 0) dep[cur]--;
				CMD_FIND: begin
					s = in_run(it.task_pid);
					if (s < 0)
						sts = STS_NOTFOUND;
					else
						ans = pid[s];
				end
				default: ;
			endcase
			exp_item.status = sts;
			exp_item.answer_pid = ans;
			exp_item.running_pid = pid[cur];
			exp_item.switched = (cur != was);
			pending.push_back(exp_item);
		endfunction

		function void check(out_item_t r);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
				errors++;
			end
			if (r.answer_pid !== e.answer_pid) begin
				$display("%0t: answer_pid expected %0d actual %0d", $time, e.answer_pid,
					r.answer_pid);
				errors++;
			end
			if (r.running_pid !== e.running_pid) begin
				$display("%0t: running_pid expected %0d actual %0d", $time, e.running_pid,
					r.running_pid);
				errors++;
			end
			if (r.switched !== e.switched) begin
				$display("%0t: switched expected %0d actual %0d", $time, e.switched, r.switched);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 0;
	logic      arst_n = 0;
	logic      req_valid = 0;
	logic      req_ready;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 0;
	out_item_t rsp;
	logic      cfg_we = 0;
	logic [7:0] cfg_wdata = 0;

	sched_scoreboard table_model = new();
	bit quiet = 0;        // no idling on either side
	bit long_hold = 0;    // receiver backs off for a long stretch
	int stalled_cycles = 0;

	counter_recharge_task_scheduler DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// handshakes are sampled mid-cycle, where everything driven at the edge has settled
	always @(negedge clk) begin
		if (arst_n && req_valid && req_ready)
			table_model.note(req);
		if (arst_n && rsp_valid && rsp_ready)
			table_model.check(rsp);
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			stalled_cycles = 0;
		else
			stalled_cycles++;
		if (stalled_cycles >= 8000) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random back-pressure bursts, plus one long hold-off on request
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (long_hold) begin
				rsp_ready <= 0;
				repeat (400) @(posedge clk);
				long_hold = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_ready <= 0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			rsp_ready <= 1;
			@(posedge clk);
		end
	end

	// offer one item and hold it until taken, then maybe leave a gap
	task automatic send_event(in_item_t it);
		req <= it;
		req_valid <= 1;
		do
			@(negedge clk);
		while (!req_ready);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic send_cmd(cmd_e c, logic [15:0] tp, logic [15:0] wp, logic [7:0] p,
			logic [7:0] d, bit w);
		in_item_t it;
		it.cmd = c;
		it.task_pid = tp;
		it.wait_pid = wp;
		it.prio = p;
		it.lock_depth_init = d;
		it.waitable = w;
		send_event(it);
	endtask

	// mostly live pids so kills, waits and finds hit; small priorities keep schedules frequent
	function automatic in_item_t random_event();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.cmd = r < 22 ? CMD_ADD : r < 45 ? CMD_TICK : r < 52 ? CMD_YIELD :
			r < 60 ? CMD_KILL : r < 67 ? CMD_WAIT : r < 73 ? CMD_CHECK :
			r < 79 ? CMD_REAP : r < 84 ? CMD_POFF : r < 89 ? CMD_PON :
			r < 97 ? CMD_FIND : 4'($urandom_range(10, 15));
		it.task_pid = $urandom_range(0, 6) != 0 ? table_model.pid[$urandom_range(0, 15)]
			: 16'($urandom);
		it.wait_pid = $urandom_range(0, 6) != 0 ? table_model.pid[$urandom_range(0, 15)]
			: 16'($urandom);
		it.prio = $urandom_range(0, 4) != 0 ? 8'($urandom_range(0, 7)) : 8'($urandom);
		it.lock_depth_init = $urandom_range(0, 3) != 0 ? 8'd0 : 8'($urandom);
		it.waitable = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic wait_drained();
		req_valid <= 0;
		while (table_model.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_boot_prio(logic [7:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		table_model.write_boot(v);
	endtask

	initial begin
		logic [7:0] boot_values[4];
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: boot task recharge, every command, pid extremes, wake on a stopped task
		send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 16'h0000, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 16'hffff, 16'hffff, 8'hff, 8'hff, 1);
		send_cmd(CMD_ADD, 0, 0, 8'hff, 8'h00, 1);
		send_cmd(CMD_ADD, 16'hffff, 16'hffff, 8'h00, 8'hff, 0);
		send_cmd(CMD_ADD, 0, 0, 8'd3, 8'd0, 1);
		send_cmd(CMD_YIELD, 0, 0, 0, 0, 0);
		send_cmd(CMD_POFF, 0, 0, 0, 0, 0);
		send_cmd(CMD_TICK, 0, 0, 0, 0, 0);
		send_cmd(CMD_PON, 0, 0, 0, 0, 0);
		send_cmd(CMD_PON, 0, 0, 0, 0, 0);
		send_cmd(CMD_KILL, 16'hffff, 0, 0, 0, 0);
		send_cmd(CMD_WAIT, 16'd3, 16'd1, 0, 0, 0);
		send_cmd(CMD_WAIT, 16'd3, 16'hfff0, 0, 0, 0);
		send_cmd(CMD_KILL, 16'd1, 0, 0, 0, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 16'd3, 0, 0, 0, 0);
		send_cmd(CMD_REAP, 0, 0, 0, 0, 0);
		send_cmd(CMD_YIELD, 0, 0, 0, 0, 0);
		send_cmd(cmd_e'(4'd10), 0, 0, 0, 0, 0);
		send_cmd(cmd_e'(4'd15), 16'hffff, 16'hffff, 8'hff, 8'hff, 1);
		for (int i = 0; i < 4; i++)
			send_cmd(CMD_ADD, 0, 0, 8'd1, 8'd0, 0);
		wait_drained();

		// zero boot priority lets recharging stall; max, random and the reset value follow
		boot_values[0] = 8'd0;
		boot_values[1] = 8'hff;
		boot_values[2] = 8'($urandom);
		boot_values[3] = BOOT_PRIO_RST;
		for (int ph = 0; ph < 4; ph++) begin
			write_boot_prio(boot_values[ph]);
			for (int n = 0; n < 232; n++) begin
				if (ph == 1 && n == 40)
					long_hold = 1;
				if (ph == 3 && n == 80)
					quiet = 1;
				send_event(random_event());
			end
			wait_drained();
		end

		if (table_model.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* files.f */
hdl/crts_pkg.sv
hdl/crts_ctrl.sv
hdl/crts_dp.sv
hdl/counter_recharge_task_scheduler.sv
hdl/crts_chk.sv
dv/tb.sv
